// ===== src/min_priority_queue_assert.svh =====
// Assertion macros for the min_priority_queue block.
`ifndef MIN_PRIORITY_QUEUE_ASSERT_SVH
`define MIN_PRIORITY_QUEUE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define MPQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define MPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/mpq_pkg.sv =====
package mpq_pkg;

  localparam int KEY_W   = 32;
  localparam int COUNT_W = 7;

  localparam logic [1:0] FUNC_INSERT  = 2'd0;
  localparam logic [1:0] FUNC_EXTRACT = 2'd1;
  localparam logic [1:0] FUNC_CLEAR   = 2'd2;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  typedef struct packed {
    logic [1:0]              func;
    logic signed [KEY_W-1:0] key;
  } mpq_in_t;

  typedef struct packed {
    logic signed [KEY_W-1:0] min_key;
    logic                    key_valid;
    logic [1:0]              status;
    logic [COUNT_W-1:0]      count;
  } mpq_out_t;

  typedef struct packed {
    logic ins;
    logic ext;
    logic clr;
  } mpq_ctl_t;

endpackage

// ===== src/min_priority_queue.sv =====
// A result appears in the output register in the cycle after its input transfer.
// Throughput: one operation per cycle unless the output stalls; all cells of the sorted
// row update in parallel, so insert and extract both finish in the cycle they are accepted.
// Reset clears the occupancy flag of every cell, the key count and the output valid.
// Stored keys are not reset and are never read before they are written.
`include "min_priority_queue_assert.svh"

module min_priority_queue #(
  parameter int CAPACITY = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  mpq_pkg::mpq_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output mpq_pkg::mpq_out_t out_data
);
  import mpq_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);

  logic                    accept;
  logic                    is_full;
  logic                    is_empty;
  mpq_ctl_t                ctl;
  logic [CAPACITY-1:0]     cell_occ;
  logic [CAPACITY-1:0]     cell_lt;
  logic signed [KEY_W-1:0] cell_key [CAPACITY];
  logic [CW-1:0]           count_r;
  logic [CW-1:0]           count_nxt;
  logic                    out_valid_r;
  mpq_out_t                out_data_r;
  mpq_out_t                res_nxt;
  logic [CW+COUNT_W-1:0]   count_ext;

  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;
  assign is_full  = (count_r == CW'(CAPACITY));
  assign is_empty = (count_r == '0);

  assign ctl.ins = accept && (in_data.func == FUNC_INSERT) && !is_full;
  assign ctl.ext = accept && (in_data.func == FUNC_EXTRACT) && !is_empty;
  assign ctl.clr = accept && (in_data.func == FUNC_CLEAR);

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                    l_lt;
    logic                    l_occ;
    logic signed [KEY_W-1:0] l_key;
    logic                    r_occ;
    logic signed [KEY_W-1:0] r_key;

    if (i == 0) begin : g_first
      assign l_lt  = 1'b0;
      assign l_occ = 1'b0;
      assign l_key = '0;
    end else begin : g_mid_l
      assign l_lt  = cell_lt[i-1];
      assign l_occ = cell_occ[i-1];
      assign l_key = cell_key[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign r_occ = 1'b0;
      assign r_key = '0;
    end else begin : g_mid_r
      assign r_occ = cell_occ[i+1];
      assign r_key = cell_key[i+1];
    end

    mpq_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .new_key   (in_data.key),
      .left_lt   (l_lt),
      .left_occ  (l_occ),
      .left_key  (l_key),
      .right_occ (r_occ),
      .right_key (r_key),
      .occ       (cell_occ[i]),
      .key       (cell_key[i]),
      .lt        (cell_lt[i])
    );
  end

  always_comb begin
    count_nxt = count_r;
    if (ctl.clr) begin
      count_nxt = '0;
    end else if (ctl.ins) begin
      count_nxt = count_r + CW'(1);
    end else if (ctl.ext) begin
      count_nxt = count_r - CW'(1);
    end
  end

  assign count_ext = {{COUNT_W{1'b0}}, count_nxt};

  always_comb begin
    res_nxt           = '0;
    res_nxt.count     = count_ext[COUNT_W-1:0];
    case (in_data.func)
      FUNC_INSERT: begin
        if (is_full) begin
          res_nxt.status = STATUS_FULL;
        end
      end
      FUNC_EXTRACT: begin
        if (is_empty) begin
          res_nxt.status = STATUS_EMPTY;
        end else begin
          res_nxt.min_key   = cell_key[0];
          res_nxt.key_valid = 1'b1;
        end
      end
      default: begin
        res_nxt.status = STATUS_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `MPQ_ASSERT_NOW(a_occ_matches_count, 1'b1,
    $countones(cell_occ) == int'(count_r), "occupied cells differ from count")
  `MPQ_ASSERT_NOW(a_head_is_min, cell_occ[1],
    !(cell_key[1] < cell_key[0]), "head cell is not the minimum")
  `MPQ_ASSERT_NEXT(a_extract_returns_key, ctl.ext,
    out_valid_r && out_data_r.key_valid, "extract gave no key")
  `MPQ_ASSERT_NEXT(a_full_insert_no_store,
    accept && (in_data.func == FUNC_INSERT) && is_full,
    $stable(count_r) && (out_data_r.status == STATUS_FULL),
    "insert into full queue changed count")

endmodule

// ===== src/mpq_cell.sv =====
module mpq_cell (
  input  logic                            clk,
  input  logic                            rst_n,
  input  mpq_pkg::mpq_ctl_t               ctl,
  input  logic signed [mpq_pkg::KEY_W-1:0] new_key,
  input  logic                            left_lt,
  input  logic                            left_occ,
  input  logic signed [mpq_pkg::KEY_W-1:0] left_key,
  input  logic                            right_occ,
  input  logic signed [mpq_pkg::KEY_W-1:0] right_key,
  output logic                            occ,
  output logic signed [mpq_pkg::KEY_W-1:0] key,
  output logic                            lt
);
  import mpq_pkg::*;

  logic                    occ_r;
  logic                    occ_nxt;
  logic signed [KEY_W-1:0] key_r;
  logic signed [KEY_W-1:0] key_nxt;

  // The new key belongs in front of this cell when the cell is empty or larger.
  assign lt  = !occ_r || (new_key < key_r);
  assign occ = occ_r;
  assign key = key_r;

  always_comb begin
    occ_nxt = occ_r;
    key_nxt = key_r;
    if (ctl.clr) begin
      occ_nxt = 1'b0;
    end else if (ctl.ins) begin
      if (left_lt) begin
        occ_nxt = left_occ;
        key_nxt = left_key;
      end else if (lt) begin
        occ_nxt = 1'b1;
        key_nxt = new_key;
      end
    end else if (ctl.ext) begin
      occ_nxt = right_occ;
      key_nxt = right_key;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= 1'b0;
    end else begin
      occ_r <= occ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

endmodule

// ===== sim/tb_min_priority_queue.sv =====
module tb_min_priority_queue;
  timeunit 1ns;
  timeprecision 1ps;

  import mpq_pkg::*;

  localparam int QUEUE_DEPTH = 64;
  localparam int ITEM_TARGET = 1700;
  localparam int PHASE_LEN   = 150;
  localparam int CYCLE_LIMIT = 200000;
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  mpq_in_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  mpq_out_t out_data;

  mpq_in_t                 pending_ops[$];
  mpq_out_t                expected_results[$];
  logic signed [KEY_W-1:0] held_keys[$];
  int gen_count = 0;
  int accepted_count = 0;
  int error_count = 0;
  int cycle_count = 0;

  min_priority_queue #(.CAPACITY(QUEUE_DEPTH)) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int idle_pct(input bit receiver);
    case ((accepted_count / PHASE_LEN) % 4)
      0: return 0;
      1: return receiver ? 0 : 60;
      2: return receiver ? 60 : 0;
      default: return 7;
    endcase
  endfunction

  function automatic logic signed [KEY_W-1:0] pick_key();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0: return 32'sh8000_0000;
          1: return 32'sh7fff_ffff;
          2: return 32'sh0000_0000;
          default: return 32'shffff_ffff;
        endcase
      end
      1, 2, 3: return $urandom_range(0, 8) - 4;
      default: return $urandom();
    endcase
  endfunction

  task automatic queue_op(input logic [1:0] func, input logic signed [KEY_W-1:0] key);
    mpq_in_t op;
    op.func = func;
    op.key = key;
    pending_ops.push_back(op);
    case (func)
      FUNC_INSERT: if (gen_count < QUEUE_DEPTH) gen_count++;
      FUNC_EXTRACT: if (gen_count > 0) gen_count--;
      FUNC_CLEAR: gen_count = 0;
      default: ;
    endcase
  endtask

  // Keys of equal value are interchangeable, so only the smallest value matters.
  function automatic mpq_out_t apply_op(input mpq_in_t op);
    mpq_out_t res;
    int best;
    res = '0;
    res.status = STATUS_OK;
    case (op.func)
      FUNC_INSERT: begin
        if (held_keys.size() >= QUEUE_DEPTH) res.status = STATUS_FULL;
        else held_keys.push_back(op.key);
      end
      FUNC_EXTRACT: begin
        if (held_keys.size() == 0) begin
          res.status = STATUS_EMPTY;
        end else begin
          best = 0;
          for (int i = 1; i < held_keys.size(); i++) begin
            if (held_keys[i] < held_keys[best]) best = i;
          end
          res.min_key = held_keys[best];
          res.key_valid = 1'b1;
          held_keys.delete(best);
        end
      end
      FUNC_CLEAR: held_keys.delete();
      default: ;
    endcase
    res.count = COUNT_W'(held_keys.size());
    return res;
  endfunction

  task automatic check_result(input mpq_out_t got);
    mpq_out_t want;
    if (expected_results.size() == 0) begin
      $error("Result with no pending expectation: %p", got);
      error_count++;
    end else begin
      want = expected_results.pop_front();
      if (got.min_key !== want.min_key) begin
        $error("min_key mismatch: expected %0d, actual %0d", want.min_key, got.min_key);
        error_count++;
      end
      if (got.key_valid !== want.key_valid) begin
        $error("key_valid mismatch: expected %0d, actual %0d", want.key_valid, got.key_valid);
        error_count++;
      end
      if (got.status !== want.status) begin
        $error("status mismatch: expected %0d, actual %0d", want.status, got.status);
        error_count++;
      end
      if (got.count !== want.count) begin
        $error("count mismatch: expected %0d, actual %0d", want.count, got.count);
        error_count++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_results.push_back(apply_op(in_data));
        accepted_count++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_ops.size() != 0 && $urandom_range(0, 99) >= idle_pct(1'b0)) begin
          in_data <= pending_ops.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) check_result(out_data);
      out_stall <= $urandom_range(0, 99) < idle_pct(1'b1);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    int pick;
    int burst;

    // Directed: empty extract, extreme and duplicate keys, unused code, clear.
    queue_op(FUNC_EXTRACT, $urandom());
    queue_op(FUNC_INSERT, 32'sh7fff_ffff);
    queue_op(FUNC_INSERT, 32'sh8000_0000);
    queue_op(FUNC_INSERT, 32'sh0000_0000);
    queue_op(FUNC_INSERT, 32'shffff_ffff);
    queue_op(FUNC_INSERT, 32'sh0000_0001);
    queue_op(FUNC_INSERT, 32'shffff_ffff);
    queue_op(FUNC_UNUSED, $urandom());
    queue_op(FUNC_EXTRACT, $urandom());
    queue_op(FUNC_EXTRACT, $urandom());
    queue_op(FUNC_EXTRACT, $urandom());
    queue_op(FUNC_EXTRACT, $urandom());
    queue_op(FUNC_INSERT, 32'sh0000_0005);
    queue_op(FUNC_CLEAR, $urandom());
    queue_op(FUNC_EXTRACT, $urandom());
    queue_op(FUNC_CLEAR, $urandom());
    queue_op(FUNC_INSERT, 32'sh8000_0000);
    queue_op(FUNC_INSERT, 32'sh8000_0000);
    queue_op(FUNC_EXTRACT, $urandom());
    queue_op(FUNC_EXTRACT, $urandom());
    queue_op(FUNC_EXTRACT, $urandom());

    // Random: fill bursts run into the full case, drain bursts into the empty case.
    while (pending_ops.size() < ITEM_TARGET) begin
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        burst = QUEUE_DEPTH - gen_count + $urandom_range(1, 3);
        repeat (burst) queue_op(FUNC_INSERT, pick_key());
      end else if (pick < 25) begin
        burst = gen_count + $urandom_range(1, 3);
        repeat (burst) queue_op(FUNC_EXTRACT, $urandom());
      end else begin
        repeat (30) begin
          pick = $urandom_range(0, 99);
          if (pick < 55) queue_op(FUNC_INSERT, pick_key());
          else if (pick < 95) queue_op(FUNC_EXTRACT, $urandom());
          else if (pick < 98) queue_op(FUNC_CLEAR, $urandom());
          else queue_op(FUNC_UNUSED, $urandom());
        end
      end
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_ops.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (10) @(posedge clk);

    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
